// ===== hw/rtl/sap_pkg.sv =====
// Shared types and constants for the section address placer.
// Used by sap_overlap and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sap_pkg;

  localparam int ADDR_W           = 16;
  localparam int END_W            = ADDR_W + 1;
  localparam int MAX_SECTIONS_DEF = 16;

  localparam logic [ADDR_W-1:0] LIMIT_RESET = 16'hFF00;

  localparam logic [1:0] ST_PLACED  = 2'd0;
  localparam logic [1:0] ST_OVERLAP = 2'd1;
  localparam logic [1:0] ST_NO_ROOM = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic REQ_FIXED = 1'b0;
  localparam logic REQ_AUTO  = 1'b1;

  // One held range, closed at both ends.
  typedef struct packed {
    logic [END_W-1:0]  hi;
    logic [ADDR_W-1:0] lo;
  } range_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sap_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module sap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sap_overlap.sv =====
// Shared overlap comparator: tests a candidate range against one held range.
// Depends on sap_pkg for the range type.
`timescale 1ns / 1ps
`default_nettype none

module sap_overlap
  import sap_pkg::*;
(
  input  wire range_t held,
  input  wire range_t cand,
  output logic        hit
);

  // Closed ranges overlap when each one starts no later than the other ends.
  assign hit = ({1'b0, held.lo} <= cand.hi) && ({1'b0, cand.lo} <= held.hi);

endmodule

`default_nettype wire

// ===== hw/rtl/section_address_placer_top.sv =====
// Top level of the section address placer: sequencer, range table and limit register.
// Depends on sap_pkg, sap_ram and sap_overlap.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// A request is a transfer on the input channel: it is taken at a rising edge
// with start high and busy low. A fixed request (in_req_type 0) reserves
// in_fixed_address through in_fixed_address + in_section_size, both ends
// included. An automatic request (in_req_type 1) tries bases from
// upper_limit - 1 downward in steps of the size.
// Every request gives exactly one result transfer: out_valid is high for one
// cycle with out_placed_address and out_status; the receiver cannot stall it.
// busy stays high from the cycle after the request through the result cycle.
// A full table, or for an automatic request a zero size or a limit below two,
// goes from the accepting cycle straight to the result. A fixed request passes
// through the test state, then for each held range a table read and a compare
// through the shared overlap unit, and then the result.
// An automatic request adds, for every candidate it rejects, the limit test,
// the compares and a step to the next candidate. The table read port and the
// single comparator make the compares go one held range at a time.
// Reset (rst_n low, synchronous) empties the table and sets upper_limit to
// 0xFF00. cfg_we writes upper_limit and must only be used while busy is low.
module section_address_placer_top
  import sap_pkg::*;
#(
  parameter int MAX_SECTIONS = MAX_SECTIONS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              in_req_type,
  input  wire logic [ADDR_W-1:0] in_fixed_address,
  input  wire logic [ADDR_W-1:0] in_section_size,
  output logic                   out_valid,
  output logic      [ADDR_W-1:0] out_placed_address,
  output logic      [1:0]        out_status,
  input  wire logic              cfg_we,
  input  wire logic [ADDR_W-1:0] cfg_wdata
);

  localparam int AW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int CW = $clog2(MAX_SECTIONS + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_TEST  = 6'b000010,
    S_FETCH = 6'b000100,
    S_CMP   = 6'b001000,
    S_STEP  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] limit_r;
  logic [CW-1:0]     held_r, held_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic              kind_r, kind_nxt;
  logic [ADDR_W-1:0] size_r, size_nxt;
  range_t            cand_r, cand_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [1:0]        status_r, status_nxt;

  logic              tbl_we;
  range_t            tbl_rdata;
  logic              hit;
  logic              idx_last;
  logic              full;
  logic [END_W-1:0]  step_diff;

  sap_ram #(
    .WIDTH ($bits(range_t)),
    .DEPTH (MAX_SECTIONS)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (held_r[AW-1:0]),
    .wdata (cand_r),
    .raddr (idx_r),
    .rdata (tbl_rdata)
  );

  sap_overlap u_overlap (
    .held (tbl_rdata),
    .cand (cand_r),
    .hit  (hit)
  );

  assign idx_last  = (CW'(idx_r) + CW'(1)) == held_r;
  assign full      = held_r == CW'(MAX_SECTIONS);
  assign step_diff = {1'b0, cand_r.lo} - {1'b0, size_r};

  always_comb begin
    state_nxt  = state_r;
    held_nxt   = held_r;
    idx_nxt    = idx_r;
    kind_nxt   = kind_r;
    size_nxt   = size_r;
    cand_nxt   = cand_r;
    addr_nxt   = addr_r;
    status_nxt = status_r;
    tbl_we     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          kind_nxt  = in_req_type;
          size_nxt  = in_section_size;
          addr_nxt  = '0;
          if (in_req_type == REQ_FIXED) begin
            cand_nxt.lo = in_fixed_address;
            cand_nxt.hi = {1'b0, in_fixed_address} + {1'b0, in_section_size};
          end else begin
            cand_nxt.lo = limit_r - ADDR_W'(1);
            cand_nxt.hi = {1'b0, limit_r - ADDR_W'(1)} + {1'b0, in_section_size};
          end
          if (full) begin
            status_nxt = ST_FULL;
            state_nxt  = S_DONE;
          end else if (in_req_type == REQ_AUTO &&
                       (in_section_size == '0 || limit_r <= ADDR_W'(1))) begin
            status_nxt = ST_NO_ROOM;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_TEST;
          end
        end
      end

      S_TEST: begin
        idx_nxt = '0;
        if (kind_r == REQ_AUTO && cand_r.hi >= {1'b0, limit_r}) begin
          state_nxt = S_STEP;
        end else if (held_r == '0) begin
          tbl_we     = 1'b1;
          held_nxt   = held_r + CW'(1);
          addr_nxt   = cand_r.lo;
          status_nxt = ST_PLACED;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_FETCH;
        end
      end

      S_FETCH: begin
        state_nxt = S_CMP;
      end

      S_CMP: begin
        if (hit) begin
          if (kind_r == REQ_FIXED) begin
            status_nxt = ST_OVERLAP;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_STEP;
          end
        end else if (idx_last) begin
          tbl_we     = 1'b1;
          held_nxt   = held_r + CW'(1);
          addr_nxt   = cand_r.lo;
          status_nxt = ST_PLACED;
          state_nxt  = S_DONE;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = S_FETCH;
        end
      end

      S_STEP: begin
        // The next candidate ends where the current one begins.
        if (step_diff[END_W-1] || step_diff[ADDR_W-1:0] == '0) begin
          status_nxt = ST_NO_ROOM;
          state_nxt  = S_DONE;
        end else begin
          cand_nxt.lo = step_diff[ADDR_W-1:0];
          cand_nxt.hi = {1'b0, cand_r.lo};
          state_nxt   = S_TEST;
        end
      end

      S_DONE: begin
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      held_r  <= '0;
      limit_r <= LIMIT_RESET;
    end else begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    kind_r   <= kind_nxt;
    size_r   <= size_nxt;
    cand_r   <= cand_nxt;
    addr_r   <= addr_nxt;
    status_r <= status_nxt;
  end

  assign busy               = state_r != S_IDLE;
  assign out_valid          = state_r == S_DONE;
  assign out_placed_address = addr_r;
  assign out_status         = status_r;

  // The result strobe lasts a single cycle.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  // An accepted request keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // Only a placed section reports a nonzero address.
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_PLACED) |-> out_placed_address == '0)
    else $error("refused request reports an address");

  // The table never holds more ranges than it has entries, and grows only on placement.
  a_held_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (held_r != $past(held_r)) |-> (out_valid && out_status == ST_PLACED &&
                                   held_r <= CW'(MAX_SECTIONS)))
    else $error("held count changed without a placement");

endmodule

`default_nettype wire
